[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the barometric compensation block.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also runs during reset.
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

[rtl/bsc_pkg.sv]
// Package for the barometric sensor compensation pipeline: widths and stage structs.
// No dependencies.
package bsc_pkg;

  localparam int D_W      = 24;   // raw converter reading
  localparam int COEF_W   = 16;   // calibration coefficient
  localparam int DT_W     = 25;   // dT, signed
  localparam int PROD_W   = 42;   // dT * coefficient, signed
  localparam int DD_W     = 50;   // dT * dT, signed
  localparam int TM_W     = 19;   // TEMP - 2000
  localparam int TP_W     = 20;   // TEMP + 1500
  localparam int TEMP_W   = 19;
  localparam int OFFB_W   = 37;   // first-order OFF
  localparam int SENSB_W  = 37;   // first-order SENS
  localparam int T2_W     = 18;
  localparam int SQ_W     = 37;   // squares, unsigned
  localparam int OFF2_W   = 41;
  localparam int SENS2_W  = 40;
  localparam int OFF_W    = 42;
  localparam int SENS_W   = 41;
  localparam int PRES_W   = 32;

  localparam int TEMP_REF_CENTI = 2000;
  localparam int TEMP_LOW_CENTI = 1500;

  typedef struct packed {
    logic [COEF_W-1:0] sens_coeff;
    logic [COEF_W-1:0] off_coeff;
    logic [COEF_W-1:0] tcs_coeff;
    logic [COEF_W-1:0] tco_coeff;
    logic [COEF_W-1:0] tref_coeff;
    logic [COEF_W-1:0] tempsens_coeff;
  } bsc_cfg_t;

  // First-order results, handed from the temperature stages to the correction stages
  typedef struct packed {
    logic [D_W-1:0]            d1;
    logic signed [TM_W-1:0]    tm;
    logic signed [TP_W-1:0]    tp;
    logic signed [TEMP_W-1:0]  temp;
    logic signed [OFFB_W-1:0]  off_b;
    logic signed [SENSB_W-1:0] sens_b;
    logic [T2_W-1:0]           t2;
  } bsc_base_t;

  // Fully compensated terms, handed to the pressure stages
  typedef struct packed {
    logic [D_W-1:0]           d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } bsc_comp_t;

endpackage

[rtl/bsc_temp.sv]
// First-order stages: dT, coefficient products, TEMP and base OFF/SENS (three stages).
// Depends on bsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bsc_temp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [bsc_pkg::D_W-1:0]     d1,
  input  logic [bsc_pkg::D_W-1:0]     d2,
  input  bsc_pkg::bsc_cfg_t           cfg,
  output logic                        out_valid,
  output bsc_pkg::bsc_base_t          base
);
  import bsc_pkg::*;

  // stage 1: dT
  logic                    v1_r;
  logic signed [DT_W-1:0]  dt_r, dt_nxt;
  logic [D_W-1:0]          d1a_r;

  // stage 2: products
  logic                     v2_r;
  logic signed [PROD_W-1:0] p_ts_r, p_tco_r, p_tcs_r;
  logic signed [PROD_W-1:0] p_ts_nxt, p_tco_nxt, p_tcs_nxt;
  logic signed [DD_W-1:0]   p_dd_r, p_dd_nxt;
  logic [D_W-1:0]           d1b_r;

  // stage 3
  logic                      v3_r;
  bsc_base_t                 base_r, base_nxt;
  logic signed [TM_W-1:0]    tm_c;

  assign dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, cfg.tref_coeff, 8'h00});

  assign p_ts_nxt  = dt_r * $signed({1'b0, cfg.tempsens_coeff});
  assign p_tco_nxt = dt_r * $signed({1'b0, cfg.tco_coeff});
  assign p_tcs_nxt = dt_r * $signed({1'b0, cfg.tcs_coeff});
  assign p_dd_nxt  = dt_r * dt_r;

  // floor(dT*TEMPSENS / 2^23) is TEMP - 2000
  assign tm_c = p_ts_r[PROD_W-1:23];

  always_comb begin
    base_nxt        = '0;
    base_nxt.d1     = d1b_r;
    base_nxt.tm     = tm_c;
    base_nxt.tp     = {tm_c[TM_W-1], tm_c} + TP_W'(TEMP_REF_CENTI + TEMP_LOW_CENTI);
    base_nxt.temp   = tm_c + TEMP_W'(TEMP_REF_CENTI);
    base_nxt.off_b  = $signed({4'b0, cfg.off_coeff, 17'b0})
                    + $signed({p_tco_r[PROD_W-1], p_tco_r[PROD_W-1:6]});
    base_nxt.sens_b = $signed({5'b0, cfg.sens_coeff, 16'b0})
                    + $signed({{2{p_tcs_r[PROD_W-1]}}, p_tcs_r[PROD_W-1:7]});
    base_nxt.t2     = p_dd_r[48:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dt_r    <= dt_nxt;
      d1a_r   <= d1;
      p_ts_r  <= p_ts_nxt;
      p_tco_r <= p_tco_nxt;
      p_tcs_r <= p_tcs_nxt;
      p_dd_r  <= p_dd_nxt;
      d1b_r   <= d1a_r;
      base_r  <= base_nxt;
    end
  end

  assign out_valid = v3_r;
  assign base      = base_r;

  `ASSERT_CLK(a_ts_zero, clk, rst_n, adv && v1_r && cfg.tempsens_coeff == '0 |=> p_ts_r == '0, "zero TEMPSENS gave nonzero product")

endmodule

[rtl/bsc_corr.sv]
// Second-order correction stages: squares, OFF2/SENS2/T2 and their subtraction.
// Depends on bsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bsc_corr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  bsc_pkg::bsc_base_t  base,
  output logic                out_valid,
  output bsc_pkg::bsc_comp_t  comp
);
  import bsc_pkg::*;

  // stage 4: squares
  logic                  v4_r, cold4_r, vcold4_r;
  bsc_base_t             b4_r;
  logic [SQ_W-1:0]       sqm_r, sqp_r, sqm_nxt, sqp_nxt;
  logic signed [2*TM_W-1:0] sqm_full;
  logic signed [2*TP_W-1:0] sqp_full;

  // stage 5: correction terms
  logic                  v5_r, cold5_r;
  bsc_base_t             b5_r;
  logic [OFF2_W-1:0]     off2_r, off2_nxt;
  logic [SENS2_W-1:0]    sens2_r, sens2_nxt;
  logic [SQ_W+5:0]       m61;

  // stage 6
  logic                  v6_r;
  bsc_comp_t             comp_r, comp_nxt;
  logic signed [OFF_W-1:0]  offb_ext;
  logic signed [SENS_W-1:0] sensb_ext;

  assign sqm_full = base.tm * base.tm;
  assign sqp_full = base.tp * base.tp;
  assign sqm_nxt  = sqm_full[SQ_W-1:0];
  assign sqp_nxt  = sqp_full[SQ_W-1:0];

  assign m61       = {6'b0, sqm_r} * (SQ_W+6)'(61);
  assign off2_nxt  = {2'b0, m61[SQ_W+5:4]}
                   + (vcold4_r ? ({4'b0, sqp_r} * OFF2_W'(15)) : OFF2_W'(0));
  assign sens2_nxt = {2'b0, sqm_r, 1'b0} + (vcold4_r ? {sqp_r, 3'b0} : SENS2_W'(0));

  assign offb_ext  = {{(OFF_W-OFFB_W){b5_r.off_b[OFFB_W-1]}}, b5_r.off_b};
  assign sensb_ext = {{(SENS_W-SENSB_W){b5_r.sens_b[SENSB_W-1]}}, b5_r.sens_b};

  always_comb begin
    comp_nxt    = '0;
    comp_nxt.d1 = b5_r.d1;
    if (cold5_r) begin
      comp_nxt.temp = b5_r.temp - $signed({1'b0, b5_r.t2});
      comp_nxt.off  = offb_ext - $signed({1'b0, off2_r});
      comp_nxt.sens = sensb_ext - $signed({1'b0, sens2_r});
    end else begin
      comp_nxt.temp = b5_r.temp;
      comp_nxt.off  = offb_ext;
      comp_nxt.sens = sensb_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v4_r <= in_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b4_r     <= base;
      sqm_r    <= sqm_nxt;
      sqp_r    <= sqp_nxt;
      cold4_r  <= base.tm[TM_W-1];
      vcold4_r <= base.tp[TP_W-1];
      b5_r     <= b4_r;
      cold5_r  <= cold4_r;
      off2_r   <= off2_nxt;
      sens2_r  <= sens2_nxt;
      comp_r   <= comp_nxt;
    end
  end

  assign out_valid = v6_r;
  assign comp      = comp_r;

  `ASSERT_CLK(a_warm_off, clk, rst_n, adv && v5_r && !cold5_r |=> comp_r.off == $past(offb_ext), "warm item OFF altered")
  `ASSERT_CLK(a_warm_temp, clk, rst_n, adv && v5_r && !cold5_r |=> comp_r.temp == $past(b5_r.temp), "warm item TEMP altered")

endmodule

[rtl/bsc_pres.sv]
// Pressure stages: D1*SENS split in two partial products, shift, OFF subtract, output.
// Depends on bsc_pkg.
module bsc_pres (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  bsc_pkg::bsc_comp_t            comp,
  output logic                          out_valid,
  output logic signed [bsc_pkg::TEMP_W-1:0] temperature_centi,
  output logic signed [bsc_pkg::PRES_W-1:0] pressure_pa
);
  import bsc_pkg::*;

  localparam int LO_W   = 20;
  localparam int HI_W   = SENS_W - LO_W;
  localparam int PLO_W  = D_W + LO_W;
  localparam int PHI_W  = D_W + 1 + HI_W;
  localparam int FULL_W = PHI_W + LO_W;
  localparam int SH_W   = FULL_W - 21;
  localparam int DIF_W  = SH_W + 1;

  // stage 7: partial products
  logic                     v7_r;
  logic [PLO_W-1:0]         plo_r, plo_nxt;
  logic signed [PHI_W-1:0]  phi_r, phi_nxt;
  logic signed [OFF_W-1:0]  off7_r;
  logic signed [TEMP_W-1:0] temp7_r;
  logic signed [HI_W-1:0]   sens_hi;

  // stage 8: full product, floor shift by 21
  logic                     v8_r;
  logic [FULL_W-1:0]        full_c;
  logic signed [SH_W-1:0]   sh_r;
  logic signed [OFF_W-1:0]  off8_r;
  logic signed [TEMP_W-1:0] temp8_r;

  // stage 9: subtract OFF, floor shift by 15
  logic                     v9_r;
  logic signed [DIF_W-1:0]  diff_c;
  logic signed [PRES_W-1:0] pres_r, pres_nxt;
  logic signed [TEMP_W-1:0] temp9_r;

  assign sens_hi = comp.sens[SENS_W-1:LO_W];
  assign plo_nxt = comp.d1 * comp.sens[LO_W-1:0];
  assign phi_nxt = $signed({1'b0, comp.d1}) * sens_hi;

  assign full_c = {phi_r, {LO_W{1'b0}}} + {{(FULL_W-PLO_W){1'b0}}, plo_r};

  // |D1*SENS| < 2^64, so the shifted difference fits 31 bits and is sign-extended without a clamp
  assign diff_c   = {sh_r[SH_W-1], sh_r} - {{(DIF_W-OFF_W){off8_r[OFF_W-1]}}, off8_r};
  assign pres_nxt = {{(PRES_W-(DIF_W-15)){diff_c[DIF_W-1]}}, diff_c[DIF_W-1:15]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (adv) begin
      v7_r <= in_valid;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
      off7_r  <= comp.off;
      temp7_r <= comp.temp;
      sh_r    <= full_c[FULL_W-1:21];
      off8_r  <= off7_r;
      temp8_r <= temp7_r;
      pres_r  <= pres_nxt;
      temp9_r <= temp8_r;
    end
  end

  assign out_valid         = v9_r;
  assign temperature_centi = temp9_r;
  assign pressure_pa       = pres_r;

endmodule

[rtl/baro_sensor_compensation.sv]
// Top level of the barometric sensor compensation block: APB registers and pipeline.
// Depends on bsc_pkg, bsc_temp, bsc_corr, bsc_pres and assert_macros.svh.
//
//   channel   ports                                   dir   notes
//   --------  --------------------------------------  ----  ------------------------------
//   in        in_valid/in_ready, raw_pressure/_temp    in    one request = one D1/D2 pair
//   out       out_valid/out_ready, temperature/press.  out   one result per request
//   cfg       cfg_psel..cfg_pready, 5-bit paddr        in    six 16-bit coefficients, 4*i
//
// Nine-stage pipeline; a new request is taken every cycle while the output is not
// backed up.
// All stages advance together; out_valid high with out_ready low freezes every stage
// and drops in_ready in the same cycle, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears the valid bits and all six coefficients.
`include "assert_macros.svh"
module baro_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bsc_pkg::D_W-1:0]           in_raw_pressure,
  input  logic [bsc_pkg::D_W-1:0]           in_raw_temperature,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bsc_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic signed [bsc_pkg::PRES_W-1:0] out_pressure_pa,
  // configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [4:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import bsc_pkg::*;

  // register index (paddr[4:2])
  localparam logic [2:0] REG_SENS     = 3'd0;
  localparam logic [2:0] REG_OFF      = 3'd1;
  localparam logic [2:0] REG_TCS      = 3'd2;
  localparam logic [2:0] REG_TCO      = 3'd3;
  localparam logic [2:0] REG_TREF     = 3'd4;
  localparam logic [2:0] REG_TEMPSENS = 3'd5;

  bsc_cfg_t   cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic       adv;

  logic       v_temp, v_corr;
  bsc_base_t  base;
  bsc_comp_t  comp;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SENS:     cfg_r.sens_coeff     <= cfg_pwdata[COEF_W-1:0];
        REG_OFF:      cfg_r.off_coeff      <= cfg_pwdata[COEF_W-1:0];
        REG_TCS:      cfg_r.tcs_coeff      <= cfg_pwdata[COEF_W-1:0];
        REG_TCO:      cfg_r.tco_coeff      <= cfg_pwdata[COEF_W-1:0];
        REG_TREF:     cfg_r.tref_coeff     <= cfg_pwdata[COEF_W-1:0];
        REG_TEMPSENS: cfg_r.tempsens_coeff <= cfg_pwdata[COEF_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SENS:     cfg_prdata = {16'b0, cfg_r.sens_coeff};
      REG_OFF:      cfg_prdata = {16'b0, cfg_r.off_coeff};
      REG_TCS:      cfg_prdata = {16'b0, cfg_r.tcs_coeff};
      REG_TCO:      cfg_prdata = {16'b0, cfg_r.tco_coeff};
      REG_TREF:     cfg_prdata = {16'b0, cfg_r.tref_coeff};
      REG_TEMPSENS: cfg_prdata = {16'b0, cfg_r.tempsens_coeff};
      default:      cfg_prdata = 32'b0;
    endcase
  end

  // whole pipe moves unless a finished result is waiting on the output
  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  // stages 1-3: dT, products, first-order TEMP/OFF/SENS
  bsc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .d1        (in_raw_pressure),
    .d2        (in_raw_temperature),
    .cfg       (cfg_r),
    .out_valid (v_temp),
    .base      (base)
  );

  // stages 4-6: second-order correction below 20.00 C
  bsc_corr u_corr (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v_temp),
    .base      (base),
    .out_valid (v_corr),
    .comp      (comp)
  );

  // stages 7-9: pressure, last stage is the output register
  bsc_pres u_pres (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .in_valid          (v_corr),
    .comp              (comp),
    .out_valid         (out_valid),
    .temperature_centi (out_temperature_centi),
    .pressure_pa       (out_pressure_pa)
  );

  `ASSERT_NORST(a_rst_clears, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `ASSERT_CLK(a_ready_tracks, clk, rst_n, out_valid && !out_ready |=> out_valid, "stalled result dropped by pipeline")

endmodule
